// ===== rtl/wtsw_pkg.sv =====
// ----------------------------------------------------------------------------
// Wait-table stall watchdog package
// Shared types, operation and status codes, register indexes and resets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wtsw_pkg;

    // Operation codes of a request transaction
    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_END    = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;
    // Spare code: no state change and no result
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Result status codes
    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_FULL    = 3'd1;
    localparam logic [2:0] STAT_NOMATCH = 3'd2;
    localparam logic [2:0] STAT_STALL   = 3'd3;
    localparam logic [2:0] STAT_TIMEOUT = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = CFG_IDX_W'(1);

    // Register reset values
    localparam logic [31:0] TIMEOUT_RESET = 32'd100;
    localparam logic [15:0] LIMIT_RESET   = 16'd100;

    // Saturation point of the unchanged-tick counter
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] thread_id;
        logic [31:0] resource_id;
        logic [31:0] now_tick;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot_index;
        logic [31:0] stalled_thread;
        logic [31:0] stalled_resource;
        logic [31:0] waited_ticks;
    } rsp_t;

    // One word of the slot memory
    typedef struct packed {
        logic        active;
        logic [31:0] thread;
        logic [31:0] resource;
        logic [31:0] since_tick;
    } slot_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DONE
    } scan_state_t;

endpackage

// ===== rtl/wtsw_mem.sv =====
// ----------------------------------------------------------------------------
// Wait-table slot memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wtsw_mem #(
    parameter int SLOTS = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] waddr,
    input  wtsw_pkg::slot_t                         wdata,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] raddr,
    output wtsw_pkg::slot_t                         rdata
);

    wtsw_pkg::slot_t mem [SLOTS];
    wtsw_pkg::slot_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/wtsw_tick.sv =====
// ----------------------------------------------------------------------------
// Wait-table tick tracker
// Counts consecutive checks that see the same nonzero tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wtsw_tick (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        upd,
    input  logic [31:0] now_tick,
    input  logic [15:0] limit,
    output logic        stall
);

    logic [31:0] last_seen_reg;
    logic [31:0] last_seen_next;
    logic [15:0] unchanged_reg;
    logic [15:0] unchanged_next;
    logic        same_tick;
    logic [15:0] cnt_inc;

    always_comb
    begin
        same_tick = (now_tick == last_seen_reg) && (now_tick != 32'd0);
        cnt_inc   = (unchanged_reg == wtsw_pkg::CNT_MAX) ? unchanged_reg
                                                         : unchanged_reg + 16'd1;
        stall     = same_tick && (cnt_inc > limit);

        last_seen_next = last_seen_reg;
        unchanged_next = unchanged_reg;
        if (upd)
        begin
            if (same_tick)
            begin
                unchanged_next = cnt_inc;
            end
            else
            begin
                unchanged_next = 16'd0;
                last_seen_next = now_tick;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seen_reg <= 32'd0;
            unchanged_reg <= 16'd0;
        end
        else
        begin
            last_seen_reg <= last_seen_next;
            unchanged_reg <= unchanged_next;
        end
    end

`ifndef NO_ASSERTIONS
    // counter only steps by one or drops to zero
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (unchanged_reg != $past(unchanged_reg)) |->
        (unchanged_reg == 16'd0 || unchanged_reg == $past(unchanged_reg) + 16'd1))
        else $error("unchanged-tick counter jumped");

    a_last_upd: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(last_seen_reg) |-> $past(upd))
        else $error("last seen tick changed without a check");
`endif

endmodule

// ===== rtl/wtsw_scan.sv =====
// ----------------------------------------------------------------------------
// Wait-table scan sequencer
// Clears the slot memory after reset, then walks it at most once per transaction
// with a registered read and writes back the slot that a begin or end hit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wtsw_scan #(
    parameter int SLOTS = 64
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  wtsw_pkg::req_t                          req,
    input  logic                                    accept,
    input  logic                                    stall_hit,
    input  logic [31:0]                             timeout,
    input  logic                                    out_free,
    output logic                                    busy,
    output logic                                    done,
    output wtsw_pkg::rsp_t                          res,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] mem_raddr,
    input  wtsw_pkg::slot_t                         mem_rdata,
    output logic                                    mem_we,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] mem_waddr,
    output wtsw_pkg::slot_t                         mem_wdata
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    wtsw_pkg::scan_state_t state_reg, state_next;
    logic [AW-1:0]         rd_addr_reg, rd_addr_next;
    logic                  issue_reg, issue_next;
    logic                  chk_valid_reg, chk_valid_next;
    logic [AW-1:0]         chk_addr_reg, chk_addr_next;
    wtsw_pkg::req_t        item_reg, item_next;
    wtsw_pkg::rsp_t        res_reg, res_next;
    logic [31:0]           waited;
    logic                  hit;

    // slot test on the word read back this cycle
    always_comb
    begin
        waited = item_reg.now_tick - mem_rdata.since_tick;
        case (item_reg.op)
            wtsw_pkg::OP_BEGIN: hit = !mem_rdata.active;
            wtsw_pkg::OP_END:   hit = mem_rdata.active &&
                                      (mem_rdata.thread == item_reg.thread_id);
            wtsw_pkg::OP_CHECK: hit = mem_rdata.active && (waited > timeout);
            default:            hit = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        rd_addr_next   = rd_addr_reg;
        issue_next     = issue_reg;
        chk_valid_next = 1'b0;
        chk_addr_next  = chk_addr_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = chk_addr_reg;
        mem_wdata      = '0;

        case (state_reg)
            wtsw_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = rd_addr_reg;
                if (rd_addr_reg == LAST)
                begin
                    rd_addr_next = '0;
                    state_next   = wtsw_pkg::S_IDLE;
                end
                else
                begin
                    rd_addr_next = rd_addr_reg + AW'(1);
                end
            end

            wtsw_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    item_next    = req;
                    rd_addr_next = '0;
                    issue_next   = 1'b1;
                    if (req.op == wtsw_pkg::OP_CHECK && stall_hit)
                    begin
                        res_next        = '0;
                        res_next.status = wtsw_pkg::STAT_STALL;
                        state_next      = wtsw_pkg::S_DONE;
                    end
                    else if (req.op == wtsw_pkg::OP_BEGIN || req.op == wtsw_pkg::OP_END ||
                             req.op == wtsw_pkg::OP_CHECK)
                    begin
                        state_next = wtsw_pkg::S_SCAN;
                    end
                end
            end

            wtsw_pkg::S_SCAN:
            begin
                if (issue_reg)
                begin
                    chk_valid_next = 1'b1;
                    chk_addr_next  = rd_addr_reg;
                    rd_addr_next   = rd_addr_reg + AW'(1);
                    issue_next     = (rd_addr_reg != LAST);
                end
                if (chk_valid_reg)
                begin
                    if (hit)
                    begin
                        res_next            = '0;
                        res_next.slot_index = 6'(chk_addr_reg);
                        state_next          = wtsw_pkg::S_DONE;
                        case (item_reg.op)
                            wtsw_pkg::OP_BEGIN:
                            begin
                                res_next.status      = wtsw_pkg::STAT_OK;
                                mem_we               = 1'b1;
                                mem_wdata.active     = 1'b1;
                                mem_wdata.thread     = item_reg.thread_id;
                                mem_wdata.resource   = item_reg.resource_id;
                                mem_wdata.since_tick = item_reg.now_tick;
                            end
                            wtsw_pkg::OP_END:
                            begin
                                res_next.status = wtsw_pkg::STAT_OK;
                                mem_we          = 1'b1;
                            end
                            default:
                            begin
                                res_next.status           = wtsw_pkg::STAT_TIMEOUT;
                                res_next.stalled_thread   = mem_rdata.thread;
                                res_next.stalled_resource = mem_rdata.resource;
                                res_next.waited_ticks     = waited;
                            end
                        endcase
                    end
                    else if (chk_addr_reg == LAST)
                    begin
                        res_next   = '0;
                        state_next = wtsw_pkg::S_DONE;
                        case (item_reg.op)
                            wtsw_pkg::OP_BEGIN: res_next.status = wtsw_pkg::STAT_FULL;
                            wtsw_pkg::OP_END:   res_next.status = wtsw_pkg::STAT_NOMATCH;
                            default:            res_next.status = wtsw_pkg::STAT_OK;
                        endcase
                    end
                end
            end

            wtsw_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = wtsw_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = wtsw_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wtsw_pkg::S_CLEAR;
            rd_addr_reg   <= '0;
            issue_reg     <= 1'b0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_addr_reg   <= rd_addr_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_addr_reg <= chk_addr_next;
        item_reg     <= item_next;
        res_reg      <= res_next;
    end

    assign mem_raddr = rd_addr_reg;
    assign busy      = (state_reg != wtsw_pkg::S_IDLE);
    assign done      = (state_reg == wtsw_pkg::S_DONE);
    assign res       = res_reg;

`ifndef NO_ASSERTIONS
    a_we_src: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == wtsw_pkg::S_CLEAR ||
                    (state_reg == wtsw_pkg::S_SCAN && chk_valid_reg)))
        else $error("slot write outside clear or scan");

    a_timeout_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wtsw_pkg::S_DONE && res_reg.status == wtsw_pkg::STAT_TIMEOUT) |->
        (item_reg.op == wtsw_pkg::OP_CHECK))
        else $error("timeout reported for a non-check transaction");
`endif

endmodule

// ===== rtl/wait_table_stall_watchdog.sv =====
// ----------------------------------------------------------------------------
// Wait-table stall watchdog
// Flow: a timer stall on a check goes straight to the done state; other
//   transactions walk the slot memory in order until a hit or the last slot.
// Throughput: one transaction at a time, with no new one taken before the
//   last is through; req_stall is low only while the sequencer is idle.
// Reset: the reset registers return to defaults at once; a clearing pass
//   then zeroes the slot memory while req_stall stays high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wait_table_stall_watchdog #(
    parameter int SLOTS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             req_valid,
    output logic                             req_stall,
    input  wtsw_pkg::req_t                   req,
    // result channel
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output wtsw_pkg::rsp_t                   rsp,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wtsw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_data
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // configuration registers
    logic [31:0] timeout_reg;
    logic [15:0] limit_reg;

    // output register parts the sequencer from the consumer
    logic           rsp_valid_reg;
    wtsw_pkg::rsp_t rsp_reg;

    logic            accept;
    logic            busy;
    logic            done;
    logic            out_free;
    logic            stall_hit;
    logic            tick_upd;
    wtsw_pkg::rsp_t  scan_res;
    logic [AW-1:0]   mem_raddr;
    logic [AW-1:0]   mem_waddr;
    logic            mem_we;
    wtsw_pkg::slot_t mem_wdata;
    wtsw_pkg::slot_t mem_rdata;

    assign req_stall = busy;
    assign accept    = req_valid && !busy;
    // tick tracker advances on every accepted check transaction
    assign tick_upd  = accept && (req.op == wtsw_pkg::OP_CHECK);
    // result slot is free when empty or being drained this cycle
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // config writes always land; software writes are to come only while idle, which the block does not enforce
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= wtsw_pkg::TIMEOUT_RESET;
            limit_reg   <= wtsw_pkg::LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // unknown indexes drop silently
            if (cfg_index == wtsw_pkg::CFG_TIMEOUT)
            begin
                timeout_reg <= cfg_data;
            end
            else if (cfg_index == wtsw_pkg::CFG_LIMIT)
            begin
                limit_reg <= cfg_data[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            rsp_valid_reg <= done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && out_free)
        begin
            rsp_reg <= scan_res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    wtsw_tick u_tick (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (tick_upd),
        .now_tick (req.now_tick),
        .limit    (limit_reg),
        .stall    (stall_hit)
    );

    wtsw_mem #(
        .SLOTS (SLOTS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    wtsw_scan #(
        .SLOTS (SLOTS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .accept    (accept),
        .stall_hit (stall_hit),
        .timeout   (timeout_reg),
        .out_free  (out_free),
        .busy      (busy),
        .done      (done),
        .res       (scan_res),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata)
    );

`ifndef NO_ASSERTIONS
    // a real transaction always makes the sequencer busy right after it is taken
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.op != wtsw_pkg::OP_UNUSED) |=> req_stall)
        else $error("sequencer idle right after taking a transaction");
`endif

endmodule
